@@ rtl/core/expression_token_lexer_top_defines.svh @@
// ---------------------------------------------------------------------------
// expression token lexer assertion macros
// shared clocked assertion forms used by the lexer rtl
// ---------------------------------------------------------------------------
`ifndef EXPRESSION_TOKEN_LEXER_TOP_DEFINES_SVH
`define EXPRESSION_TOKEN_LEXER_TOP_DEFINES_SVH

// property must hold at every edge outside reset
`define ETL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ETL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ETL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/etl_pkg.sv @@
// ---------------------------------------------------------------------------
// expression token lexer package
// token kinds, error codes and the structs passed between lexer modules
// ---------------------------------------------------------------------------
`default_nettype none

package etl_pkg;

   // output field widths
   localparam int OUT_POS_W = 16;
   localparam int KIND_W    = 5;
   localparam int ERR_W     = 3;

   // token kinds
   localparam logic [KIND_W-1:0] K_END   = 5'd0;
   localparam logic [KIND_W-1:0] K_NUM   = 5'd1;
   localparam logic [KIND_W-1:0] K_IDENT = 5'd2;
   localparam logic [KIND_W-1:0] K_PLUS  = 5'd3;
   localparam logic [KIND_W-1:0] K_MINUS = 5'd4;
   localparam logic [KIND_W-1:0] K_STAR  = 5'd5;
   localparam logic [KIND_W-1:0] K_SLASH = 5'd6;
   localparam logic [KIND_W-1:0] K_PCT   = 5'd7;
   localparam logic [KIND_W-1:0] K_CARET = 5'd8;
   localparam logic [KIND_W-1:0] K_LPAR  = 5'd9;
   localparam logic [KIND_W-1:0] K_RPAR  = 5'd10;
   localparam logic [KIND_W-1:0] K_COMMA = 5'd11;
   localparam logic [KIND_W-1:0] K_QUEST = 5'd12;
   localparam logic [KIND_W-1:0] K_COLON = 5'd13;
   localparam logic [KIND_W-1:0] K_NE    = 5'd14;
   localparam logic [KIND_W-1:0] K_NOT   = 5'd15;
   localparam logic [KIND_W-1:0] K_EQEQ  = 5'd16;
   localparam logic [KIND_W-1:0] K_GE    = 5'd17;
   localparam logic [KIND_W-1:0] K_GT    = 5'd18;
   localparam logic [KIND_W-1:0] K_LE    = 5'd19;
   localparam logic [KIND_W-1:0] K_LT    = 5'd20;
   localparam logic [KIND_W-1:0] K_AND   = 5'd21;
   localparam logic [KIND_W-1:0] K_OR    = 5'd22;
   localparam logic [KIND_W-1:0] K_ERR   = 5'd23;

   // error codes
   localparam logic [ERR_W-1:0] E_NONE    = 3'd0;
   localparam logic [ERR_W-1:0] E_LONE_EQ = 3'd1;
   localparam logic [ERR_W-1:0] E_LONE_AMP = 3'd2;
   localparam logic [ERR_W-1:0] E_LONE_BAR = 3'd3;
   localparam logic [ERR_W-1:0] E_UNKNOWN = 3'd4;
   localparam logic [ERR_W-1:0] E_TOO_LONG = 3'd5;

   // character class of one input byte
   typedef struct packed {
      logic              digit;
      logic              dot;
      logic              exp_e;
      logic              sign;
      logic              word;
      logic              space;
      logic              bang;
      logic              eq;
      logic              gt;
      logic              lt;
      logic              amp;
      logic              bar;
      logic              single;
      logic [KIND_W-1:0] single_kind;
   } char_class_type;

   // one result transaction
   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [OUT_POS_W-1:0] start;
      logic [OUT_POS_W-1:0] len;
      logic [ERR_W-1:0]     err;
      logic                 last;
   } etl_result_type;

   // results written into the output buffer by one accepted transaction
   typedef struct packed {
      logic       valid;
      logic [1:0] count;
   } etl_push_type;

endpackage

`default_nettype wire

@@ rtl/core/etl_classify.sv @@
// ---------------------------------------------------------------------------
// expression token lexer character classifier
// decodes one input byte into the classes the lexer rules test
// ---------------------------------------------------------------------------
`default_nettype none

module etl_classify (
   input  wire logic [7:0]             char_byte,
   output etl_pkg::char_class_type     char_class
);
   import etl_pkg::*;

   localparam logic [7:0] C_DOT   = 8'h2E;
   localparam logic [7:0] C_LOW_E = 8'h65;
   localparam logic [7:0] C_UP_E  = 8'h45;
   localparam logic [7:0] C_UNDER = 8'h5F;
   localparam logic [7:0] C_EQ    = 8'h3D;
   localparam logic [7:0] C_AMP   = 8'h26;
   localparam logic [7:0] C_BAR   = 8'h7C;
   localparam logic [7:0] C_BANG  = 8'h21;
   localparam logic [7:0] C_GT    = 8'h3E;
   localparam logic [7:0] C_LT    = 8'h3C;
   localparam logic [7:0] C_PLUS  = 8'h2B;
   localparam logic [7:0] C_MINUS = 8'h2D;
   localparam logic [7:0] C_SPACE = 8'h20;
   localparam logic [7:0] C_TAB   = 8'h09;
   localparam logic [7:0] C_CR    = 8'h0D;

   logic is_alpha;

   // range classes
   assign is_alpha = (char_byte >= 8'h61 && char_byte <= 8'h7A) ||
                     (char_byte >= 8'h41 && char_byte <= 8'h5A);

   always_comb begin
      char_class.digit = (char_byte >= 8'h30 && char_byte <= 8'h39);
      char_class.dot   = (char_byte == C_DOT);
      char_class.exp_e = (char_byte == C_LOW_E) || (char_byte == C_UP_E);
      char_class.sign  = (char_byte == C_PLUS) || (char_byte == C_MINUS);
      char_class.word  = is_alpha || (char_byte == C_UNDER);
      char_class.space = (char_byte == C_SPACE) ||
                         (char_byte >= C_TAB && char_byte <= C_CR);
      char_class.bang  = (char_byte == C_BANG);
      char_class.eq    = (char_byte == C_EQ);
      char_class.gt    = (char_byte == C_GT);
      char_class.lt    = (char_byte == C_LT);
      char_class.amp   = (char_byte == C_AMP);
      char_class.bar   = (char_byte == C_BAR);

      // single-character operators
      char_class.single      = 1'b1;
      char_class.single_kind = K_PLUS;
      unique case (char_byte)
         8'h2B:   char_class.single_kind = K_PLUS;
         8'h2D:   char_class.single_kind = K_MINUS;
         8'h2A:   char_class.single_kind = K_STAR;
         8'h2F:   char_class.single_kind = K_SLASH;
         8'h25:   char_class.single_kind = K_PCT;
         8'h5E:   char_class.single_kind = K_CARET;
         8'h28:   char_class.single_kind = K_LPAR;
         8'h29:   char_class.single_kind = K_RPAR;
         8'h2C:   char_class.single_kind = K_COMMA;
         8'h3F:   char_class.single_kind = K_QUEST;
         8'h3A:   char_class.single_kind = K_COLON;
         default: char_class.single      = 1'b0;
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/core/etl_lexer.sv @@
// ---------------------------------------------------------------------------
// expression token lexer state machine
// holds the lex mode and positions and forms up to two results per byte
// ---------------------------------------------------------------------------
`default_nettype none

module etl_lexer #(
   parameter int POS_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept,
   input  wire logic                   action,
   input  etl_pkg::char_class_type     char_class,
   output etl_pkg::etl_push_type       push,
   output etl_pkg::etl_result_type     result0,
   output etl_pkg::etl_result_type     result1
);
   import etl_pkg::*;

   localparam int EXT_W = (POS_BITS > OUT_POS_W) ? POS_BITS : OUT_POS_W;

   // lex modes
   localparam logic [3:0] M_IDLE    = 4'd0;
   localparam logic [3:0] M_MANT    = 4'd1;
   localparam logic [3:0] M_EXPS    = 4'd2;
   localparam logic [3:0] M_EXPSIGN = 4'd3;
   localparam logic [3:0] M_EXPD    = 4'd4;
   localparam logic [3:0] M_IDENT   = 4'd5;
   localparam logic [3:0] M_BANG    = 4'd6;
   localparam logic [3:0] M_EQ      = 4'd7;
   localparam logic [3:0] M_GT      = 4'd8;
   localparam logic [3:0] M_LT      = 4'd9;
   localparam logic [3:0] M_AMP     = 4'd10;
   localparam logic [3:0] M_BAR     = 4'd11;
   localparam logic [3:0] M_ERR     = 4'd12;

   logic [3:0]          mode_ff, mode_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic [POS_BITS-1:0] tstart_ff, tstart_in;

   logic [POS_BITS-1:0]  span;
   logic [EXT_W-1:0]     pos_ext, tstart_ext, span_ext;
   logic [OUT_POS_W-1:0] pos_out, tstart_out, span_out;
   logic                 at_max;

   logic              fin_pend, fin_to_err;
   logic [KIND_W-1:0] fin_kind;
   logic [ERR_W-1:0]  fin_err;

   logic              take, pair_v;
   logic [3:0]        take_mode;
   logic [KIND_W-1:0] pair_kind;

   logic           fin_v, sec_v;
   etl_result_type fin_r, sec_r;

   // position arithmetic
   assign span       = pos_ff - tstart_ff;
   assign pos_ext    = EXT_W'(pos_ff);
   assign tstart_ext = EXT_W'(tstart_ff);
   assign span_ext   = EXT_W'(span);
   assign pos_out    = pos_ext[OUT_POS_W-1:0];
   assign tstart_out = tstart_ext[OUT_POS_W-1:0];
   assign span_out   = span_ext[OUT_POS_W-1:0];
   assign at_max     = &pos_ff;

   // pending token closed by the current byte or end marker
   always_comb begin
      fin_pend   = 1'b1;
      fin_to_err = 1'b0;
      fin_kind   = K_NUM;
      fin_err    = E_NONE;
      unique case (mode_ff)
         M_MANT, M_EXPS, M_EXPSIGN, M_EXPD: fin_kind = K_NUM;
         M_IDENT: fin_kind = K_IDENT;
         M_BANG:  fin_kind = K_NOT;
         M_GT:    fin_kind = K_GT;
         M_LT:    fin_kind = K_LT;
         M_EQ: begin
            fin_kind   = K_ERR;
            fin_err    = E_LONE_EQ;
            fin_to_err = 1'b1;
         end
         M_AMP: begin
            fin_kind   = K_ERR;
            fin_err    = E_LONE_AMP;
            fin_to_err = 1'b1;
         end
         M_BAR: begin
            fin_kind   = K_ERR;
            fin_err    = E_LONE_BAR;
            fin_to_err = 1'b1;
         end
         default: fin_pend = 1'b0;
      endcase
   end

   // continuation of the pending token and two-character operators
   always_comb begin
      take      = 1'b0;
      take_mode = mode_ff;
      pair_v    = 1'b0;
      pair_kind = K_NE;
      unique case (mode_ff)
         M_MANT: begin
            if (char_class.digit || char_class.dot) begin
               take = 1'b1;
            end else if (char_class.exp_e) begin
               take      = 1'b1;
               take_mode = M_EXPS;
            end
         end
         M_EXPS: begin
            if (char_class.sign) begin
               take      = 1'b1;
               take_mode = M_EXPSIGN;
            end else if (char_class.digit) begin
               take      = 1'b1;
               take_mode = M_EXPD;
            end
         end
         M_EXPSIGN, M_EXPD: begin
            if (char_class.digit) begin
               take      = 1'b1;
               take_mode = M_EXPD;
            end
         end
         M_IDENT: take = char_class.digit || char_class.word;
         M_BANG: begin
            pair_v    = char_class.eq;
            pair_kind = K_NE;
         end
         M_EQ: begin
            pair_v    = char_class.eq;
            pair_kind = K_EQEQ;
         end
         M_GT: begin
            pair_v    = char_class.eq;
            pair_kind = K_GE;
         end
         M_LT: begin
            pair_v    = char_class.eq;
            pair_kind = K_LE;
         end
         M_AMP: begin
            pair_v    = char_class.amp;
            pair_kind = K_AND;
         end
         M_BAR: begin
            pair_v    = char_class.bar;
            pair_kind = K_OR;
         end
         default: take = 1'b0;
      endcase
   end

   // next state and the results of one transaction
   always_comb begin
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      tstart_in = tstart_ff;
      fin_v     = 1'b0;
      sec_v     = 1'b0;
      sec_r     = '{kind: K_END, start: pos_out, len: '0, err: E_NONE, last: 1'b0};
      if (accept) begin
         priority if (action) begin
            // end marker: flush pending token, then end
            fin_v     = fin_pend;
            sec_v     = 1'b1;
            mode_in   = M_IDLE;
            pos_in    = '0;
            tstart_in = '0;
         end else if (mode_ff == M_ERR) begin
            // drop bytes, saturating position
            if (!at_max) begin
               pos_in = pos_ff + POS_BITS'(1);
            end
         end else if (at_max) begin
            // input past the position range
            mode_in   = M_ERR;
            sec_v     = 1'b1;
            sec_r.kind = K_ERR;
            sec_r.err  = E_TOO_LONG;
         end else begin
            pos_in = pos_ff + POS_BITS'(1);
            priority if (pair_v) begin
               sec_v       = 1'b1;
               sec_r.kind  = pair_kind;
               sec_r.start = tstart_out;
               sec_r.len   = OUT_POS_W'(2);
               mode_in     = M_IDLE;
            end else if (take) begin
               mode_in = take_mode;
            end else begin
               fin_v = fin_pend;
               if (fin_to_err) begin
                  mode_in = M_ERR;
               end else begin
                  mode_in = M_IDLE;
                  if (!char_class.space) begin
                     tstart_in = pos_ff;
                  end
                  // byte opens a new token
                  priority if (char_class.space) begin
                     mode_in = M_IDLE;
                  end else if (char_class.digit || char_class.dot) begin
                     mode_in = M_MANT;
                  end else if (char_class.word) begin
                     mode_in = M_IDENT;
                  end else if (char_class.single) begin
                     sec_v      = 1'b1;
                     sec_r.kind = char_class.single_kind;
                     sec_r.len  = OUT_POS_W'(1);
                  end else if (char_class.bang) begin
                     mode_in = M_BANG;
                  end else if (char_class.eq) begin
                     mode_in = M_EQ;
                  end else if (char_class.gt) begin
                     mode_in = M_GT;
                  end else if (char_class.lt) begin
                     mode_in = M_LT;
                  end else if (char_class.amp) begin
                     mode_in = M_AMP;
                  end else if (char_class.bar) begin
                     mode_in = M_BAR;
                  end else begin
                     mode_in    = M_ERR;
                     sec_v      = 1'b1;
                     sec_r.kind = K_ERR;
                     sec_r.err  = E_UNKNOWN;
                     sec_r.len  = OUT_POS_W'(1);
                  end
               end
            end
         end
      end
   end

   // closed pending token
   assign fin_r = '{kind: fin_kind, start: tstart_out, len: span_out, err: fin_err,
                    last: !sec_v};

   // order the results, last flag on the final one
   always_comb begin
      result1      = sec_r;
      result1.last = 1'b1;
      if (fin_v) begin
         result0 = fin_r;
      end else begin
         result0      = sec_r;
         result0.last = 1'b1;
      end
      push.valid = accept;
      push.count = {1'b0, fin_v} + {1'b0, sec_v};
   end

   // lexer state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_IDLE;
         pos_ff    <= '0;
         tstart_ff <= '0;
      end else begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         tstart_ff <= tstart_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/etl_out_buf.sv @@
// ---------------------------------------------------------------------------
// expression token lexer result buffer
// two result registers that decouple the byte side from the token side
// ---------------------------------------------------------------------------
`default_nettype none

`include "expression_token_lexer_top_defines.svh"

module etl_out_buf (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  etl_pkg::etl_push_type       push,
   input  etl_pkg::etl_result_type     result0,
   input  etl_pkg::etl_result_type     result1,
   output logic                        in_ready,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output etl_pkg::etl_result_type     out_result
);
   import etl_pkg::*;

   logic [1:0]     occ_ff, occ_in;
   etl_result_type slot0_ff, slot0_in;
   etl_result_type slot1_ff, slot1_in;
   logic           pop;

   // handshake
   assign out_valid  = (occ_ff != 2'd0);
   assign out_result = slot0_ff;
   assign pop        = out_valid && out_ready;
   assign in_ready   = (occ_ff == 2'd0) || ((occ_ff == 2'd1) && out_ready);

   // fill and drain
   always_comb begin
      occ_in   = occ_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (push.valid) begin
         occ_in   = push.count;
         slot0_in = result0;
         slot1_in = result1;
      end else if (pop) begin
         occ_in   = occ_ff - 2'd1;
         slot0_in = slot1_ff;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   // occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 2'd0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   `ETL_ASSERT_IMP(a_push_room, clock, reset, push.valid, (occ_ff == 2'd0) || ((occ_ff == 2'd1) && pop), "results pushed into an occupied buffer")
   `ETL_ASSERT_NEXT(a_two_held, clock, reset, push.valid && (push.count == 2'd2), occ_ff == 2'd2, "second result of a transaction lost")
   `ETL_ASSERT_IMP(a_first_not_last, clock, reset, occ_ff == 2'd2, !slot0_ff.last && slot1_ff.last, "last flag on wrong result of a pair")

endmodule

`default_nettype wire

@@ rtl/core/expression_token_lexer_top.sv @@
// ---------------------------------------------------------------------------
// expression token lexer
// streams characters of an arithmetic expression and emits located tokens
// ---------------------------------------------------------------------------
// Takes one character per cycle (req_tuser low) or an end marker (req_tuser
// high) while req_tready is high and returns tokens with kind, start offset,
// length and error code; results come out in the cycle after the byte is
// taken and rsp_tlast marks the last result of each input. A byte that gives
// two results (a token closed by a single-character operator or unknown byte,
// or an end marker after a pending token) holds req_tready low while the second
// result register drains. Otherwise one byte per cycle is sustained while
// rsp_tready is high; the result register pair sets this, and req_tready
// follows rsp_tready in the same cycle. No clearing pass is needed after reset.
`default_nettype none

module expression_token_lexer_top #(
   parameter int POS_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] char_byte
   input  wire logic        req_tuser,    // [0] action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,    // [15:0] start_pos, [31:16] token_length,
                                          // [34:32] error_code, [39:35] zero
   output logic [4:0]       rsp_tuser,    // [4:0] token_kind
   output logic             rsp_tlast     // last_of_run
);
   import etl_pkg::*;

   char_class_type char_class;
   etl_push_type   push;
   etl_result_type result0, result1, out_result;
   logic           accept;

   // input transaction
   assign accept = req_tvalid && req_tready;

   etl_classify u_classify (
      .char_byte  (req_tdata),
      .char_class (char_class)
   );

   etl_lexer #(
      .POS_BITS (POS_BITS)
   ) u_lexer (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .action     (req_tuser),
      .char_class (char_class),
      .push       (push),
      .result0    (result0),
      .result1    (result1)
   );

   etl_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .result0    (result0),
      .result1    (result1),
      .in_ready   (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (out_result)
   );

   // result packing
   assign rsp_tdata = {5'b0, out_result.err, out_result.len, out_result.start};
   assign rsp_tuser = out_result.kind;
   assign rsp_tlast = out_result.last;

endmodule

`default_nettype wire

@@ tb/sv/tb_expression_token_lexer_top.sv @@
// ---------------------------------------------------------------------------
// expression token lexer testbench
// streams directed and random expressions into the lexer, predicts
// every token in a behavioral lexer and checks each result transaction in
// order under several sender and receiver idling mixes
// ---------------------------------------------------------------------------
module tb_expression_token_lexer_top;
   timeunit 1ns;
   timeprecision 1ps;

   import etl_pkg::*;

   // one input transaction: end marker flag and character
   typedef struct packed {
      logic       act;
      logic [7:0] ch;
   } lex_item_type;

   // lexer modes of the behavioral predictor
   typedef enum logic [3:0] {
      LX_IDLE, LX_MANT, LX_EXP_MARK, LX_EXP_SIGN, LX_EXP_DIGIT, LX_IDENT,
      LX_BANG, LX_EQ, LX_GT, LX_LT, LX_AMP, LX_BAR, LX_ERROR
   } lex_mode_type;

   localparam logic [15:0] POS_LAST = 16'hFFFF;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [4:0]  rsp_tuser;
   logic        rsp_tlast;

   // stimulus feed and token expectations
   lex_item_type   char_feed_q[$];
   etl_result_type step_toks[$];
   etl_result_type token_exp_q[$];
   int             feed_total = 0;
   int             items_taken = 0;
   int             fail_count = 0;
   int             send_idle_pct = 0;
   int             recv_stall_pct = 0;

   // long receiver hold-off
   int hold_left = 0;
   int hold_asked = 0;
   int hold_done = 0;

   // predictor state
   lex_mode_type lx_mode  = LX_IDLE;
   logic [15:0]  lx_pos   = '0;
   logic [15:0]  lx_start = '0;

   expression_token_lexer_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   // character classes
   function automatic logic is_dig(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == " " || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   task automatic add_tok(input logic [4:0] kind, input logic [15:0] start,
                          input logic [15:0] len, input logic [2:0] err);
      etl_result_type t;
      t.kind  = kind;
      t.start = start;
      t.len   = len;
      t.err   = err;
      t.last  = 1'b0;
      step_toks.insert(step_toks.size(), t);
   endtask

   // emit the pending token that ends before position p
   task automatic close_pending(input logic [15:0] p);
      logic [15:0] len;
      len = p - lx_start;
      case (lx_mode)
         LX_MANT, LX_EXP_MARK, LX_EXP_SIGN, LX_EXP_DIGIT: begin
            add_tok(K_NUM, lx_start, len, E_NONE);
            lx_mode = LX_IDLE;
         end
         LX_IDENT: begin
            add_tok(K_IDENT, lx_start, len, E_NONE);
            lx_mode = LX_IDLE;
         end
         LX_BANG: begin
            add_tok(K_NOT, lx_start, len, E_NONE);
            lx_mode = LX_IDLE;
         end
         LX_GT: begin
            add_tok(K_GT, lx_start, len, E_NONE);
            lx_mode = LX_IDLE;
         end
         LX_LT: begin
            add_tok(K_LT, lx_start, len, E_NONE);
            lx_mode = LX_IDLE;
         end
         LX_EQ: begin
            add_tok(K_ERR, lx_start, len, E_LONE_EQ);
            lx_mode = LX_ERROR;
         end
         LX_AMP: begin
            add_tok(K_ERR, lx_start, len, E_LONE_AMP);
            lx_mode = LX_ERROR;
         end
         LX_BAR: begin
            add_tok(K_ERR, lx_start, len, E_LONE_BAR);
            lx_mode = LX_ERROR;
         end
         default: ;
      endcase
   endtask

   // byte seen with no token pending
   task automatic open_token(input logic [7:0] c, input logic [15:0] p);
      if (!is_space(c)) begin
         lx_start = p;
         if (is_dig(c) || c == ".") begin
            lx_mode = LX_MANT;
         end else if (is_alpha(c) || c == "_") begin
            lx_mode = LX_IDENT;
         end else begin
            case (c)
               "+": add_tok(K_PLUS, p, 16'd1, E_NONE);
               "-": add_tok(K_MINUS, p, 16'd1, E_NONE);
               "*": add_tok(K_STAR, p, 16'd1, E_NONE);
               "/": add_tok(K_SLASH, p, 16'd1, E_NONE);
               "%": add_tok(K_PCT, p, 16'd1, E_NONE);
               "^": add_tok(K_CARET, p, 16'd1, E_NONE);
               "(": add_tok(K_LPAR, p, 16'd1, E_NONE);
               ")": add_tok(K_RPAR, p, 16'd1, E_NONE);
               ",": add_tok(K_COMMA, p, 16'd1, E_NONE);
               "?": add_tok(K_QUEST, p, 16'd1, E_NONE);
               ":": add_tok(K_COLON, p, 16'd1, E_NONE);
               "!": lx_mode = LX_BANG;
               "=": lx_mode = LX_EQ;
               ">": lx_mode = LX_GT;
               "<": lx_mode = LX_LT;
               "&": lx_mode = LX_AMP;
               "|": lx_mode = LX_BAR;
               default: begin
                  lx_mode = LX_ERROR;
                  add_tok(K_ERR, p, 16'd1, E_UNKNOWN);
               end
            endcase
         end
      end
   endtask

   // predict the tokens caused by one accepted transaction
   task automatic lex_predict(input logic act, input logic [7:0] c);
      logic [15:0] p;
      logic        take;
      logic [4:0]  pair;
      p    = lx_pos;
      take = 1'b0;
      pair = K_END;   // no two-character operator
      step_toks.delete();
      if (act) begin
         if (lx_mode != LX_ERROR) close_pending(p);
         add_tok(K_END, p, 16'd0, E_NONE);
         lx_mode  = LX_IDLE;
         lx_pos   = '0;
         lx_start = '0;
      end else if (lx_mode == LX_ERROR) begin
         // dropped byte, position saturates
         if (p != POS_LAST) lx_pos = p + 16'd1;
      end else if (p == POS_LAST) begin
         lx_mode = LX_ERROR;
         add_tok(K_ERR, p, 16'd0, E_TOO_LONG);
      end else begin
         case (lx_mode)
            LX_MANT: begin
               if (is_dig(c) || c == ".") begin
                  take = 1'b1;
               end else if (c == "e" || c == "E") begin
                  take    = 1'b1;
                  lx_mode = LX_EXP_MARK;
               end
            end
            LX_EXP_MARK: begin
               if (c == "+" || c == "-") begin
                  take    = 1'b1;
                  lx_mode = LX_EXP_SIGN;
               end else if (is_dig(c)) begin
                  take    = 1'b1;
                  lx_mode = LX_EXP_DIGIT;
               end
            end
            LX_EXP_SIGN, LX_EXP_DIGIT: begin
               if (is_dig(c)) begin
                  take    = 1'b1;
                  lx_mode = LX_EXP_DIGIT;
               end
            end
            LX_IDENT: take = is_dig(c) || is_alpha(c) || c == "_";
            LX_BANG:  if (c == "=") pair = K_NE;
            LX_EQ:    if (c == "=") pair = K_EQEQ;
            LX_GT:    if (c == "=") pair = K_GE;
            LX_LT:    if (c == "=") pair = K_LE;
            LX_AMP:   if (c == "&") pair = K_AND;
            LX_BAR:   if (c == "|") pair = K_OR;
            default: ;
         endcase
         if (pair != K_END) begin
            add_tok(pair, lx_start, 16'd2, E_NONE);
            lx_mode = LX_IDLE;
         end else if (!take) begin
            close_pending(p);
            if (lx_mode != LX_ERROR) begin
               lx_mode = LX_IDLE;
               open_token(c, p);
            end
         end
         lx_pos = p + 16'd1;
      end
      if (step_toks.size() != 0) step_toks[step_toks.size() - 1].last = 1'b1;
      foreach (step_toks[i]) token_exp_q.insert(token_exp_q.size(), step_toks[i]);
   endtask

   // stimulus helpers
   task automatic push_char(input logic [7:0] c);
      lex_item_type it;
      it.act = 1'b0;
      it.ch  = c;
      char_feed_q.insert(char_feed_q.size(), it);
      feed_total++;
   endtask

   task automatic push_end;
      lex_item_type it;
      it.act = 1'b1;
      it.ch  = 8'($urandom_range(0, 255));
      char_feed_q.insert(char_feed_q.size(), it);
      feed_total++;
   endtask

   task automatic push_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) push_char(s[i]);
   endtask

   function automatic logic [7:0] space_byte;
      int r;
      r = $urandom_range(0, 5);
      return (r == 5) ? 8'h20 : 8'(8'h09 + r);
   endfunction

   function automatic logic [7:0] word_byte(input logic lead);
      int r;
      r = $urandom_range(0, lead ? 52 : 62);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      if (r == 52) return "_";
      return 8'("0" + r - 53);
   endfunction

   // one random token, mostly well formed
   task automatic feed_token;
      string singles;
      string pairs[6];
      int    n;
      singles = "+-*/%^(),?:";
      pairs   = '{"!=", "==", ">=", "<=", "&&", "||"};
      case ($urandom_range(0, 11))
         0, 1, 2: begin
            n = $urandom_range(1, 4);
            repeat (n) push_char(8'("0" + $urandom_range(0, 9)));
            if ($urandom_range(0, 2) == 0) push_char(".");
            if ($urandom_range(0, 3) == 0) begin
               push_char($urandom_range(0, 1) ? "e" : "E");
               if ($urandom_range(0, 1)) push_char($urandom_range(0, 1) ? "+" : "-");
               repeat ($urandom_range(0, 2)) push_char(8'("0" + $urandom_range(0, 9)));
            end
         end
         3, 4, 5: begin
            push_char(word_byte(1'b1));
            repeat ($urandom_range(0, 5)) push_char(word_byte(1'b0));
         end
         6, 7: push_char(singles[$urandom_range(0, 10)]);
         8, 9: push_text(pairs[$urandom_range(0, 5)]);
         10: begin
            n = $urandom_range(0, 2);
            push_char(n == 0 ? "!" : (n == 1 ? ">" : "<"));
         end
         default: begin
            // broken operator: lone '=', '&' or '|'
            n = $urandom_range(0, 2);
            push_char(n == 0 ? "=" : (n == 1 ? "&" : "|"));
         end
      endcase
   endtask

   task automatic feed_random(input int n_items);
      int first_total;
      first_total = feed_total;
      while (feed_total - first_total < n_items) begin
         if ($urandom_range(0, 9) == 0) begin
            // raw noise bytes
            repeat ($urandom_range(1, 6)) push_char(8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 8)) begin
               feed_token();
               if ($urandom_range(0, 2) == 0) push_char(space_byte());
            end
         end
         if ($urandom_range(0, 9) != 0) push_end();
      end
   endtask

   // pause the sender until all tokens are back
   task automatic wait_drained;
      while (items_taken != feed_total || token_exp_q.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t mismatch %s expected %0d actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   // driver: predicts on each accepted transaction and offers the next one
   always @(posedge clock) begin
      lex_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            lex_predict(req_tuser, req_tdata);
            items_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (char_feed_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               nxt = char_feed_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= nxt.ch;
               req_tuser  <= nxt.act;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long hold-off counter
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_done != hold_asked) begin
         hold_left <= 300;
         hold_done <= hold_done + 1;
      end
   end

   // monitor: compares each result transaction with the oldest expectation
   always @(posedge clock) begin
      etl_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (token_exp_q.size() == 0) begin
               $display("%0t unexpected token kind %0d start %0d length %0d", $time,
                        rsp_tuser, rsp_tdata[15:0], rsp_tdata[31:16]);
               fail_count++;
            end else begin
               want = token_exp_q.pop_front();
               check_field("token_kind", 16'(want.kind), 16'(rsp_tuser));
               check_field("start_pos", want.start, rsp_tdata[15:0]);
               check_field("token_length", want.len, rsp_tdata[31:16]);
               check_field("error_code", 16'(want.err), 16'(rsp_tdata[34:32]));
               check_field("last_of_run", 16'(want.last), 16'(rsp_tlast));
            end
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // watchdog
   initial begin
      #400_000;
      $display("FAIL");
      $finish;
   end

   // stimulus sequence
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: exponent with sign, identifier, lone '=', bytes 0x00 and 0xff,
      // pending operators closed by the end marker
      push_text("1.5e-3+_Z9");
      push_end();
      push_text("=x");
      push_end();
      push_char(8'h00);
      push_char(8'hFF);
      push_end();
      push_text("!");
      push_end();
      push_text("&");
      push_end();

      hold_asked++;
      feed_random(370);
      wait_drained();

      send_idle_pct = 46;
      feed_random(360);
      wait_drained();

      send_idle_pct  = 0;
      recv_stall_pct = 46;
      feed_random(360);
      wait_drained();

      send_idle_pct  = 17;
      recv_stall_pct = 17;
      hold_asked++;
      feed_random(360);
      wait_drained();

      repeat (10) @(posedge clock);
      if (fail_count == 0 && token_exp_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
